// ----- hw/rtl/taylor_series_trig_unit_top_defines.svh -----
// Assertion macros shared by the Taylor-series trigonometric unit.
`ifndef TAYLOR_SERIES_TRIG_UNIT_TOP_DEFINES_SVH
`define TAYLOR_SERIES_TRIG_UNIT_TOP_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define TSTU_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tstu assertion failed");

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define TSTU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tstu assertion failed");

`endif

// ----- hw/rtl/tstu_pkg.sv -----
// Types, constants and the series ratio function of the trigonometric unit.
package tstu_pkg;

  // Internal magnitudes are capped at 2^62.
  localparam int MAG_W      = 63;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int SUM_W      = 64;
  localparam int RAT_W      = 16;
  localparam int CNT_W      = 7;
  localparam int K_W        = 8;
  localparam int THR_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [63:0] MAG_CAP     = 64'h4000_0000_0000_0000;
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

  // Operation codes.
  localparam logic [2:0] OP_SIN  = 3'd0;
  localparam logic [2:0] OP_COS  = 3'd1;
  localparam logic [2:0] OP_TAN  = 3'd2;
  localparam logic [2:0] OP_ASIN = 3'd3;
  localparam logic [2:0] OP_ACOS = 3'd4;
  localparam logic [2:0] OP_ATAN = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOCONV  = 2'd1;
  localparam logic [1:0] ST_TANZERO = 2'd2;
  localparam logic [1:0] ST_SAT     = 2'd3;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TERMS = 2'd1;
  localparam logic [THR_W-1:0]     THR_RESET     = 16'd168;
  localparam logic [CNT_W-1:0]     MAXT_RESET    = 7'd32;

  typedef enum logic [1:0] {K_SIN, K_COS, K_ASIN, K_ATAN} kind_t;

  // Operand selection for the shared multiply/divide unit.
  typedef enum logic [2:0] {SRC_X2, SRC_TERM, SRC_RATIO, SRC_DIV, SRC_TAN} src_t;

  typedef struct packed {
    logic load_in;
    logic mdu_start;
    src_t src;
    logic save_x2;
    logic init_series;
    logic add_term;
    logic save_mag_mul;
    logic save_mag_div;
    logic end_series;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic mdu_busy;
    logic mdu_done;
    logic term_small;
    logic count_hit;
    logic op_unused;
    logic op_tan;
    logic pass2;
    logic cos_zero;
  } sts_t;

  typedef struct packed {
    logic [RAT_W-1:0] num;
    logic [RAT_W-1:0] den;
  } ratio_t;

  // Ratio num/den that turns term k into term k+1, with k the terms added so far.
  function automatic ratio_t ratio_fn(input kind_t kind, input logic [K_W-1:0] k);
    logic [K_W-1:0] two_k;
    logic [K_W-1:0] two_k_m1;
    logic [K_W-1:0] two_k_p1;
    ratio_t r;
    two_k    = k << 1;
    two_k_m1 = two_k - K_W'(1);
    two_k_p1 = two_k + K_W'(1);
    unique case (kind)
      K_SIN: begin
        r.num = RAT_W'(1);
        r.den = RAT_W'(two_k) * RAT_W'(two_k_p1);
      end
      K_COS: begin
        r.num = RAT_W'(1);
        r.den = RAT_W'(two_k_m1) * RAT_W'(two_k);
      end
      K_ASIN: begin
        r.num = RAT_W'(two_k_m1) * RAT_W'(two_k_m1);
        r.den = RAT_W'(two_k) * RAT_W'(two_k_p1);
      end
      K_ATAN: begin
        r.num = RAT_W'(two_k_m1);
        r.den = RAT_W'(two_k_p1);
      end
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/tstu_mdu.sv -----
// Shared iterative unit: shift-add multiplier and restoring divider.
`include "taylor_series_trig_unit_top_defines.svh"

module tstu_mdu #(
  parameter int DIVN_W = 79,
  parameter int DVS_W  = 32,
  parameter int ITER_W = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        is_div,
  input  logic [tstu_pkg::MAG_W-1:0]  a,
  input  logic [tstu_pkg::MAG_W-1:0]  b,
  input  logic [ITER_W-1:0]           nbits,
  input  logic [DIVN_W-1:0]           dividend,
  input  logic [DVS_W-1:0]            divisor,
  output logic                        busy,
  output logic                        done,
  output logic [tstu_pkg::PROD_W-1:0] prod,
  output logic [DIVN_W-1:0]           quot
);

  logic                        busy_r;
  logic                        done_r;
  logic [ITER_W-1:0]           cnt_r;
  logic                        isdiv_r;
  logic [tstu_pkg::PROD_W-1:0] acc_r;
  logic [tstu_pkg::PROD_W-1:0] mcand_r;
  logic [tstu_pkg::MAG_W-1:0]  mplier_r;
  logic [DVS_W-1:0]            rem_r;
  logic [DVS_W-1:0]            dvs_r;
  logic [DIVN_W-1:0]           dvd_r;
  logic [DIVN_W-1:0]           quot_r;
  logic [DVS_W:0]              rem_sh;
  logic [DVS_W:0]              rem_new;
  logic                        fits;

  // One restoring division step: bring in the next dividend bit and try a subtract.
  always_comb begin
    rem_sh  = {rem_r, dvd_r[DIVN_W-1]};
    fits    = rem_sh >= {1'b0, dvs_r};
    rem_new = fits ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
  end

  // Iteration counter and handshake with the controller.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= is_div ? ITER_W'(DIVN_W) : nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - ITER_W'(1);
        if (cnt_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and partial-result registers, one bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      isdiv_r  <= is_div;
      acc_r    <= '0;
      mcand_r  <= tstu_pkg::PROD_W'(a);
      mplier_r <= b;
      rem_r    <= '0;
      dvs_r    <= divisor;
      dvd_r    <= dividend;
      quot_r   <= '0;
    end else if (busy_r) begin
      if (isdiv_r) begin
        rem_r  <= rem_new[DVS_W-1:0];
        dvd_r  <= dvd_r << 1;
        quot_r <= {quot_r[DIVN_W-2:0], fits};
      end else begin
        if (mplier_r[0]) begin
          acc_r <= acc_r + mcand_r;
        end
        mcand_r  <= mcand_r << 1;
        mplier_r <= mplier_r >> 1;
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = acc_r;
  assign quot = quot_r;

  `TSTU_ASSERT_NEXT(a_start_sets_busy, start, busy_r)

endmodule

// ----- hw/rtl/tstu_dp.sv -----
// Datapath: configuration, series state, operand selection and result formatting.
`include "taylor_series_trig_unit_top_defines.svh"

module tstu_dp #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tstu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tstu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [2:0]                        in_operation,
  input  logic signed [DATA_WIDTH-1:0]      in_argument,
  input  tstu_pkg::cmd_t                    cmd,
  output tstu_pkg::sts_t                    sts,
  output logic signed [DATA_WIDTH-1:0]      out_result,
  output logic [1:0]                        out_status
);

  localparam int MAG_W  = tstu_pkg::MAG_W;
  localparam int PROD_W = tstu_pkg::PROD_W;
  localparam int SUM_W  = tstu_pkg::SUM_W;
  localparam int DIVN_W = (DATA_WIDTH + FRAC_BITS > MAG_W + tstu_pkg::RAT_W) ?
                          DATA_WIDTH + FRAC_BITS : MAG_W + tstu_pkg::RAT_W;
  localparam int ITER_W = $clog2(DIVN_W + 1);
  localparam logic [63:0] HALF_PI =
    (tstu_pkg::HALF_PI_Q62 + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
  localparam logic signed [64:0] CLIP_MAX = (65'sd1 <<< (DATA_WIDTH - 1)) - 65'sd1;
  localparam logic signed [64:0] CLIP_MIN = -(65'sd1 <<< (DATA_WIDTH - 1));
  localparam logic signed [SUM_W-1:0] SUM_CAP = tstu_pkg::MAG_CAP;

  // Saturate a sum to the output range; the top bit flags clipping.
  function automatic logic [DATA_WIDTH:0] clip_fn(input logic signed [SUM_W-1:0] v);
    logic signed [64:0]  w;
    logic [DATA_WIDTH:0] r;
    w = 65'(v);
    if (w > CLIP_MAX) begin
      r = {1'b1, CLIP_MAX[DATA_WIDTH-1:0]};
    end else if (w < CLIP_MIN) begin
      r = {1'b1, CLIP_MIN[DATA_WIDTH-1:0]};
    end else begin
      r = {1'b0, v[DATA_WIDTH-1:0]};
    end
    return r;
  endfunction

  logic [tstu_pkg::THR_W-1:0] thr_r;
  logic [tstu_pkg::CNT_W-1:0] maxt_r;
  logic [2:0]                 op_r;
  logic [MAG_W-1:0]           xmag_r;
  logic                       xneg_r;
  logic                       pass_r;
  logic [MAG_W-1:0]           x2_r;
  logic [MAG_W-1:0]           mag_r;
  logic                       neg_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [tstu_pkg::CNT_W-1:0] cnt_r;
  logic [tstu_pkg::RAT_W-1:0] num_r;
  logic [tstu_pkg::RAT_W-1:0] den_r;
  logic signed [SUM_W-1:0]    ssum_r;
  logic                       sconv_r;
  logic                       conv_r;
  logic signed [DATA_WIDTH-1:0] out_result_r;
  logic [1:0]                 out_status_r;

  logic [DATA_WIDTH-1:0] arg_u;
  logic [DATA_WIDTH-1:0] arg_mag;
  logic [63:0]           arg_mag64;
  logic [MAG_W-1:0]      xmag_in;
  tstu_pkg::kind_t       kind;
  tstu_pkg::ratio_t      ratio;

  logic                  mdu_div;
  logic [MAG_W-1:0]      mdu_a;
  logic [MAG_W-1:0]      mdu_b;
  logic [ITER_W-1:0]     mdu_nbits;
  logic [DIVN_W-1:0]     mdu_dvd;
  logic [DATA_WIDTH-1:0] mdu_dvs;
  logic                  mdu_busy;
  logic                  mdu_done;
  logic [PROD_W-1:0]     prod;
  logic [DIVN_W-1:0]     quot;
  logic [PROD_W-1:0]     prod_sh;
  logic [MAG_W-1:0]      shr_cap;
  logic [MAG_W-1:0]      quot_cap;

  logic signed [SUM_W-1:0] term_s;
  logic signed [SUM_W-1:0] sum_raw;
  logic signed [SUM_W-1:0] sum_sat;

  logic [DATA_WIDTH:0]     sclip;
  logic [DATA_WIDTH:0]     cclip;
  logic [DATA_WIDTH-1:0]   sbits;
  logic [DATA_WIDTH-1:0]   cbits;
  logic [DATA_WIDTH-1:0]   tan_sm;
  logic [DATA_WIDTH-1:0]   tan_cm;
  logic [DIVN_W-1:0]       tan_dvd;
  logic signed [SUM_W-1:0] tan_val;
  logic signed [SUM_W-1:0] fin_val;
  logic [DATA_WIDTH:0]     fclip;
  logic signed [DATA_WIDTH-1:0] res_nxt;
  logic [1:0]              status_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= tstu_pkg::THR_RESET;
      maxt_r <= tstu_pkg::MAXT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == tstu_pkg::CFG_THRESHOLD) begin
        thr_r <= cfg_wdata[tstu_pkg::THR_W-1:0];
      end else if (cfg_index == tstu_pkg::CFG_MAX_TERMS) begin
        maxt_r <= cfg_wdata[tstu_pkg::CNT_W-1:0];
      end
    end
  end

  // Magnitude and sign of the incoming argument.
  always_comb begin
    arg_u     = in_argument;
    arg_mag   = arg_u[DATA_WIDTH-1] ? (~arg_u + DATA_WIDTH'(1)) : arg_u;
    arg_mag64 = 64'(arg_mag);
    xmag_in   = (arg_mag64 > tstu_pkg::MAG_CAP) ? tstu_pkg::MAG_CAP[MAG_W-1:0] :
                arg_mag64[MAG_W-1:0];
  end

  // Series kind; tangent runs sine first and cosine second.
  always_comb begin
    unique case (op_r)
      tstu_pkg::OP_SIN:  kind = tstu_pkg::K_SIN;
      tstu_pkg::OP_COS:  kind = tstu_pkg::K_COS;
      tstu_pkg::OP_TAN:  kind = pass_r ? tstu_pkg::K_COS : tstu_pkg::K_SIN;
      tstu_pkg::OP_ASIN: kind = tstu_pkg::K_ASIN;
      tstu_pkg::OP_ACOS: kind = tstu_pkg::K_ASIN;
      default:           kind = tstu_pkg::K_ATAN;
    endcase
  end

  // Operand selection for the shared unit.
  always_comb begin
    mdu_div   = 1'b0;
    mdu_a     = mag_r;
    mdu_b     = x2_r;
    mdu_nbits = ITER_W'(MAG_W);
    mdu_dvd   = prod[DIVN_W-1:0];
    mdu_dvs   = DATA_WIDTH'(den_r);
    unique case (cmd.src)
      tstu_pkg::SRC_X2: begin
        mdu_a = xmag_r;
        mdu_b = xmag_r;
      end
      tstu_pkg::SRC_TERM: begin
        mdu_a = mag_r;
        mdu_b = x2_r;
      end
      tstu_pkg::SRC_RATIO: begin
        mdu_b     = MAG_W'(num_r);
        mdu_nbits = ITER_W'(tstu_pkg::RAT_W);
      end
      tstu_pkg::SRC_DIV: begin
        mdu_div = 1'b1;
      end
      tstu_pkg::SRC_TAN: begin
        mdu_div = 1'b1;
        mdu_dvd = tan_dvd;
        mdu_dvs = tan_cm;
      end
      default: begin
        mdu_div = 1'b0;
      end
    endcase
  end

  tstu_mdu #(
    .DIVN_W (DIVN_W),
    .DVS_W  (DATA_WIDTH),
    .ITER_W (ITER_W)
  ) u_mdu (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mdu_start),
    .is_div   (mdu_div),
    .a        (mdu_a),
    .b        (mdu_b),
    .nbits    (mdu_nbits),
    .dividend (mdu_dvd),
    .divisor  (mdu_dvs),
    .busy     (mdu_busy),
    .done     (mdu_done),
    .prod     (prod),
    .quot     (quot)
  );

  // Fixed-point rescale of a product and capping of both unit results.
  always_comb begin
    prod_sh  = prod >> FRAC_BITS;
    shr_cap  = (prod_sh > PROD_W'(tstu_pkg::MAG_CAP)) ? tstu_pkg::MAG_CAP[MAG_W-1:0] :
               prod_sh[MAG_W-1:0];
    quot_cap = (quot > DIVN_W'(tstu_pkg::MAG_CAP)) ? tstu_pkg::MAG_CAP[MAG_W-1:0] :
               quot[MAG_W-1:0];
  end

  // Signed term added to the running sum, which saturates at the cap.
  always_comb begin
    term_s  = neg_r ? (64'sd0 - $signed({1'b0, mag_r})) : $signed({1'b0, mag_r});
    sum_raw = sum_r + term_s;
    if (sum_raw > SUM_CAP) begin
      sum_sat = SUM_CAP;
    end else if (sum_raw < -SUM_CAP) begin
      sum_sat = -SUM_CAP;
    end else begin
      sum_sat = sum_raw;
    end
    ratio = tstu_pkg::ratio_fn(kind, tstu_pkg::K_W'(cnt_r) + tstu_pkg::K_W'(1));
  end

  // Tangent operands: both sums clipped to the output range first.
  always_comb begin
    sclip   = clip_fn(ssum_r);
    cclip   = clip_fn(sum_r);
    sbits   = sclip[DATA_WIDTH-1:0];
    cbits   = cclip[DATA_WIDTH-1:0];
    tan_sm  = sbits[DATA_WIDTH-1] ? (~sbits + DATA_WIDTH'(1)) : sbits;
    tan_cm  = cbits[DATA_WIDTH-1] ? (~cbits + DATA_WIDTH'(1)) : cbits;
    tan_dvd = DIVN_W'(tan_sm) << FRAC_BITS;
    tan_val = (sbits[DATA_WIDTH-1] != cbits[DATA_WIDTH-1]) ?
              (64'sd0 - $signed({1'b0, quot_cap})) : $signed({1'b0, quot_cap});
  end

  // Final value and status of the item.
  always_comb begin
    unique case (op_r)
      tstu_pkg::OP_SIN, tstu_pkg::OP_COS, tstu_pkg::OP_ASIN, tstu_pkg::OP_ATAN: begin
        fin_val = sum_r;
      end
      tstu_pkg::OP_ACOS: fin_val = $signed(HALF_PI) - sum_r;
      tstu_pkg::OP_TAN:  fin_val = tan_val;
      default:           fin_val = '0;
    endcase
    fclip = clip_fn(fin_val);
    priority if (op_r > tstu_pkg::OP_ATAN) begin
      res_nxt    = '0;
      status_nxt = tstu_pkg::ST_OK;
    end else if (op_r == tstu_pkg::OP_TAN && sum_r == '0) begin
      res_nxt    = '0;
      status_nxt = tstu_pkg::ST_TANZERO;
    end else begin
      res_nxt = fclip[DATA_WIDTH-1:0];
      if (!conv_r) begin
        status_nxt = tstu_pkg::ST_NOCONV;
      end else if (fclip[DATA_WIDTH]) begin
        status_nxt = tstu_pkg::ST_SAT;
      end else begin
        status_nxt = tstu_pkg::ST_OK;
      end
    end
  end

  // Series state, updated on controller commands.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_operation;
      xmag_r <= xmag_in;
      xneg_r <= in_argument[DATA_WIDTH-1];
      pass_r <= 1'b0;
    end
    if (cmd.save_x2) begin
      x2_r <= shr_cap;
    end
    if (cmd.init_series) begin
      mag_r <= (kind == tstu_pkg::K_COS) ? (MAG_W'(1) << FRAC_BITS) : xmag_r;
      neg_r <= (kind == tstu_pkg::K_COS) ? 1'b0 : xneg_r;
      sum_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.add_term) begin
      sum_r <= sum_sat;
      cnt_r <= cnt_r + tstu_pkg::CNT_W'(1);
      num_r <= ratio.num;
      den_r <= ratio.den;
      if (kind != tstu_pkg::K_ASIN) begin
        neg_r <= !neg_r;
      end
    end
    if (cmd.save_mag_mul) begin
      mag_r <= shr_cap;
    end
    if (cmd.save_mag_div) begin
      mag_r <= quot_cap;
    end
    if (cmd.end_series) begin
      if (op_r == tstu_pkg::OP_TAN && !pass_r) begin
        ssum_r  <= sum_r;
        sconv_r <= sts.term_small;
        pass_r  <= 1'b1;
      end else begin
        conv_r <= sts.term_small && (op_r != tstu_pkg::OP_TAN || sconv_r);
      end
    end
    if (cmd.load_out) begin
      out_result_r <= res_nxt;
      out_status_r <= status_nxt;
    end
  end

  // Status towards the controller.
  always_comb begin
    sts.mdu_busy   = mdu_busy;
    sts.mdu_done   = mdu_done;
    sts.term_small = mag_r <= MAG_W'(thr_r);
    sts.count_hit  = cnt_r >= maxt_r;
    sts.op_unused  = op_r > tstu_pkg::OP_ATAN;
    sts.op_tan     = op_r == tstu_pkg::OP_TAN;
    sts.pass2      = pass_r;
    sts.cos_zero   = sum_r == '0;
  end

  assign out_result = out_result_r;
  assign out_status = out_status_r;

  `TSTU_ASSERT_NEXT(a_count_in_limit, cmd.add_term, cnt_r <= maxt_r)
  `TSTU_ASSERT_IMPLY(a_tan_divisor_nonzero, cmd.mdu_start && cmd.src == tstu_pkg::SRC_TAN, tan_cm != '0)

endmodule

// ----- hw/rtl/tstu_ctrl.sv -----
// Controller: sequences the series terms and the input and output beats.
`include "taylor_series_trig_unit_top_defines.svh"

module tstu_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  tstu_pkg::sts_t sts,
  output tstu_pkg::cmd_t cmd
);

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_X2_GO    = 15'b000000000000010,
    S_X2_WAIT  = 15'b000000000000100,
    S_INIT     = 15'b000000000001000,
    S_CHECK    = 15'b000000000010000,
    S_M1_GO    = 15'b000000000100000,
    S_M1_WAIT  = 15'b000000001000000,
    S_M2_GO    = 15'b000000010000000,
    S_M2_WAIT  = 15'b000000100000000,
    S_DV_GO    = 15'b000001000000000,
    S_DV_WAIT  = 15'b000010000000000,
    S_TCHK     = 15'b000100000000000,
    S_TDV_GO   = 15'b001000000000000,
    S_TDV_WAIT = 15'b010000000000000,
    S_DONE     = 15'b100000000000000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  // Next state and command decode.
  always_comb begin
    cmd       = '0;
    cmd.src   = tstu_pkg::SRC_X2;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_X2_GO;
        end
      end
      S_X2_GO: begin
        if (sts.op_unused) begin
          state_nxt = S_DONE;
        end else begin
          cmd.mdu_start = 1'b1;
          cmd.src       = tstu_pkg::SRC_X2;
          state_nxt     = S_X2_WAIT;
        end
      end
      S_X2_WAIT: begin
        if (sts.mdu_done) begin
          cmd.save_x2 = 1'b1;
          state_nxt   = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init_series = 1'b1;
        state_nxt       = S_CHECK;
      end
      S_CHECK: begin
        if (sts.term_small || sts.count_hit) begin
          cmd.end_series = 1'b1;
          if (sts.op_tan && !sts.pass2) begin
            state_nxt = S_INIT;
          end else if (sts.op_tan) begin
            state_nxt = S_TCHK;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          cmd.add_term = 1'b1;
          state_nxt    = S_M1_GO;
        end
      end
      S_M1_GO: begin
        cmd.mdu_start = 1'b1;
        cmd.src       = tstu_pkg::SRC_TERM;
        state_nxt     = S_M1_WAIT;
      end
      S_M1_WAIT: begin
        if (sts.mdu_done) begin
          cmd.save_mag_mul = 1'b1;
          state_nxt        = S_M2_GO;
        end
      end
      S_M2_GO: begin
        cmd.mdu_start = 1'b1;
        cmd.src       = tstu_pkg::SRC_RATIO;
        state_nxt     = S_M2_WAIT;
      end
      S_M2_WAIT: begin
        if (sts.mdu_done) begin
          state_nxt = S_DV_GO;
        end
      end
      S_DV_GO: begin
        cmd.mdu_start = 1'b1;
        cmd.src       = tstu_pkg::SRC_DIV;
        state_nxt     = S_DV_WAIT;
      end
      S_DV_WAIT: begin
        if (sts.mdu_done) begin
          cmd.save_mag_div = 1'b1;
          state_nxt        = S_CHECK;
        end
      end
      S_TCHK: begin
        state_nxt = sts.cos_zero ? S_DONE : S_TDV_GO;
      end
      S_TDV_GO: begin
        cmd.mdu_start = 1'b1;
        cmd.src       = tstu_pkg::SRC_TAN;
        state_nxt     = S_TDV_WAIT;
      end
      S_TDV_WAIT: begin
        if (sts.mdu_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register holds one finished beat until the receiver takes it.
  assign out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  `TSTU_ASSERT_IMPLY(a_start_unit_free, cmd.mdu_start, !sts.mdu_busy)
  `TSTU_ASSERT_IMPLY(a_load_slot_free, cmd.load_out, !out_valid_r || !out_stall)

endmodule

// ----- hw/rtl/taylor_series_trig_unit_top.sv -----
// Top level of the Taylor-series trigonometric unit.
//
// Input channel: in_valid/in_stall with in_operation (0 sin, 1 cos, 2 tan,
// 3 asin, 4 acos, 5 atan) and in_argument in signed fixed point. A beat is
// taken when in_valid is high and in_stall low. Output channel: out_valid/
// out_stall carry out_result (saturated) and out_status (ok, not converged,
// tangent cosine zero, saturated). The cfg_we/cfg_index/cfg_wdata port sets
// the term threshold (index 0) and the term limit (index 1); the user must
// write them only while idle, as the block itself does not enforce this.
// One item is worked on at a time. Each series term runs on one shared
// bit-serial multiply/divide unit: a multiply by x squared, a multiply by
// the ratio numerator and a divide by the ratio denominator. A tangent runs
// two series plus one more divide. Unused operation codes run no series.
// A finished result sits in the output register while the next beat is
// accepted; if the receiver stalls, the unit waits at the end of that next
// item until the register is free. Reset empties the output register,
// returns the controller to idle and restores threshold 168 and limit 32.
module taylor_series_trig_unit_top #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      in_operation,
  input  logic signed [DATA_WIDTH-1:0]    in_argument,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [DATA_WIDTH-1:0]    out_result,
  output logic [1:0]                      out_status,
  input  logic                            cfg_we,
  input  logic [tstu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tstu_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  tstu_pkg::cmd_t cmd;
  tstu_pkg::sts_t sts;

  tstu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tstu_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_operation (in_operation),
    .in_argument  (in_argument),
    .cmd          (cmd),
    .sts          (sts),
    .out_result   (out_result),
    .out_status   (out_status)
  );

endmodule

// ----- tb/sv/taylor_series_trig_unit_top_tb.sv -----
// Self-checking testbench for the Taylor-series trigonometric unit top level.
`timescale 1ns / 1ps

module taylor_series_trig_unit_top_tb;

  localparam int          DW          = 32;
  localparam int          FB          = 24;
  localparam longint      CYCLE_LIMIT = 40_000_000;
  localparam logic [2:0]  OP_SPARE6   = 3'd6;
  localparam logic [2:0]  OP_SPARE7   = 3'd7;
  localparam logic [31:0] ONE_Q       = 32'h0100_0000;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] arg;
    bit                 typed;
    logic [31:0]        res;
    logic [1:0]         st;
  } stim_row_t;

  typedef struct {
    logic [31:0] res;
    logic [1:0]  st;
  } trig_val_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic [2:0]                      in_operation;
  logic signed [DW-1:0]            in_argument;
  logic                            out_valid;
  logic                            out_stall;
  logic signed [DW-1:0]            out_result;
  logic [1:0]                      out_status;
  logic                            cfg_we;
  logic [tstu_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tstu_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // Shadow copy of the configuration registers.
  logic [15:0] thr_shadow;
  logic [6:0]  maxt_shadow;

  trig_val_t   pending_vals[$];
  int          err_count;
  longint      cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  logic        hold_on;

  taylor_series_trig_unit_top #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (.*);

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** taylor_series_trig_unit_top: FAILED **");
      $finish;
    end
  end

  // Magnitude helpers: shift or divide with the result capped at 2^62.
  function automatic logic [63:0] cap_shr(logic [127:0] p);
    logic [127:0] s;
    s = p >> FB;
    return (s > {64'd0, tstu_pkg::MAG_CAP}) ? tstu_pkg::MAG_CAP : s[63:0];
  endfunction

  function automatic logic [63:0] cap_div(logic [127:0] n, logic [63:0] d);
    logic [127:0] q;
    q = n / {64'd0, d};
    return (q > {64'd0, tstu_pkg::MAG_CAP}) ? tstu_pkg::MAG_CAP : q[63:0];
  endfunction

  function automatic longint add_cap(longint a, longint b);
    longint s;
    s = a + b;
    if (s > longint'(tstu_pkg::MAG_CAP)) return longint'(tstu_pkg::MAG_CAP);
    if (s < -longint'(tstu_pkg::MAG_CAP)) return -longint'(tstu_pkg::MAG_CAP);
    return s;
  endfunction

  // Sums one series; conv is cleared when the term limit is hit first.
  function automatic longint series_sum(tstu_pkg::kind_t kind, logic [63:0] xmag,
                                        bit xneg, output bit conv);
    logic [63:0] x2, mag, num, den, k;
    bit neg;
    longint acc;
    x2 = cap_shr({64'd0, xmag} * {64'd0, xmag});
    mag = (kind == tstu_pkg::K_COS) ? (64'd1 << FB) : xmag;
    neg = (kind == tstu_pkg::K_COS) ? 1'b0 : xneg;
    acc = 0;
    k = 0;
    forever begin
      if (mag <= {48'd0, thr_shadow}) begin
        conv = 1'b1;
        return acc;
      end
      if (k >= {57'd0, maxt_shadow}) begin
        conv = 1'b0;
        return acc;
      end
      acc = add_cap(acc, neg ? -longint'(mag) : longint'(mag));
      k++;
      num = 1;
      case (kind)
        tstu_pkg::K_SIN: den = (2 * k) * (2 * k + 1);
        tstu_pkg::K_COS: den = (2 * k - 1) * (2 * k);
        tstu_pkg::K_ASIN: begin
          num = (2 * k - 1) * (2 * k - 1);
          den = (2 * k) * (2 * k + 1);
        end
        default: begin
          num = 2 * k - 1;
          den = 2 * k + 1;
        end
      endcase
      if (kind != tstu_pkg::K_ASIN) neg = !neg;
      mag = cap_shr({64'd0, mag} * {64'd0, x2});
      mag = cap_div({64'd0, mag} * {64'd0, num}, den);
    end
  endfunction

  // Saturates a wide value to the 32-bit result range.
  function automatic logic [31:0] clip_word(longint v, output bit clipped);
    clipped = 1'b0;
    if (v > 64'sh7FFF_FFFF) begin
      clipped = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      clipped = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Expected result and status of one beat under the current settings.
  function automatic trig_val_t trig_value(logic [2:0] op, logic signed [31:0] arg);
    trig_val_t r;
    bit xneg, conv, cs, cc, clipped, sn, cn;
    logic [63:0] xmag, hp, q;
    logic [31:0] sbits, cbits, sm, cm;
    longint val, s, c;
    xneg = arg[31];
    xmag = xneg ? {32'd0, -arg} : {32'd0, arg};
    if (xneg && arg == 32'sh8000_0000) xmag = 64'h8000_0000;
    val = 0;
    conv = 1'b1;
    r.res = '0;
    r.st = tstu_pkg::ST_OK;
    case (op)
      tstu_pkg::OP_SIN:  val = series_sum(tstu_pkg::K_SIN, xmag, xneg, conv);
      tstu_pkg::OP_COS:  val = series_sum(tstu_pkg::K_COS, xmag, xneg, conv);
      tstu_pkg::OP_ATAN: val = series_sum(tstu_pkg::K_ATAN, xmag, xneg, conv);
      tstu_pkg::OP_ASIN, tstu_pkg::OP_ACOS: begin
        val = series_sum(tstu_pkg::K_ASIN, xmag, xneg, conv);
        if (op == tstu_pkg::OP_ACOS) begin
          hp = (tstu_pkg::HALF_PI_Q62 + (64'd1 << (61 - FB))) >> (62 - FB);
          val = longint'(hp) - val;
        end
      end
      tstu_pkg::OP_TAN: begin
        s = series_sum(tstu_pkg::K_SIN, xmag, xneg, cs);
        c = series_sum(tstu_pkg::K_COS, xmag, xneg, cc);
        sbits = clip_word(s, clipped);
        cbits = clip_word(c, clipped);
        if (cbits == 0) begin
          r.st = tstu_pkg::ST_TANZERO;
          return r;
        end
        sn = sbits[31];
        cn = cbits[31];
        sm = sn ? -sbits : sbits;
        cm = cn ? -cbits : cbits;
        q = cap_div({96'd0, sm} << FB, {32'd0, cm});
        val = (sn != cn) ? -longint'(q) : longint'(q);
        conv = cs && cc;
      end
      default: return r;
    endcase
    r.res = clip_word(val, clipped);
    if (!conv) r.st = tstu_pkg::ST_NOCONV;
    else if (clipped) r.st = tstu_pkg::ST_SAT;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h at cycle %0d", what, got, want,
             cycle_count);
    err_count++;
  endtask

  // Result side: random stall, long hold-off on request, and checking.
  always @(posedge clk) begin
    trig_val_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_vals.size() == 0) begin
          report("unexpected beat", out_result, '0);
        end else begin
          want = pending_vals.pop_front();
          if (out_result !== want.res) report("result", out_result, want.res);
          if (out_status !== want.st) report("status", {30'd0, out_status}, {30'd0, want.st});
        end
      end
      out_stall <= hold_on || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Offers one beat and records what it should produce once taken.
  task automatic send_beat(logic [2:0] op, logic signed [31:0] arg, bit typed,
                           trig_val_t fixed);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_argument <= arg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_vals.push_back(typed ? fixed : trig_value(op, arg));
  endtask

  // Settings are changed only once the unit has drained.
  task automatic set_config(logic [15:0] thr, logic [6:0] maxt);
    in_valid <= 1'b0;
    while (pending_vals.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= tstu_pkg::CFG_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_index <= tstu_pkg::CFG_MAX_TERMS;
    cfg_wdata <= {9'd0, maxt};
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_shadow = thr;
    maxt_shadow = maxt;
  endtask

  // Mostly small arguments, which converge in a few terms; some full-range words.
  function automatic logic signed [31:0] pick_arg(int wide_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < wide_pct) return $urandom();
    if (r < 70) return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
  endfunction

  function automatic logic [2:0] pick_op();
    return ($urandom_range(0, 99) < 5) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
  endfunction

  initial begin
    stim_row_t   rows[$];
    trig_val_t   probe;
    logic signed [31:0] zero_cos_arg;
    bit          zc_found;
    int          n_items;
    trig_val_t   none;
    none = '{res: '0, st: tstu_pkg::ST_OK};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = tstu_pkg::OP_SIN;
    in_argument = '0;
    cfg_we = 1'b0;
    cfg_index = tstu_pkg::CFG_THRESHOLD;
    cfg_wdata = '0;
    out_stall = 1'b0;
    hold_on = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    err_count = 0;
    cycle_count = 0;
    thr_shadow = tstu_pkg::THR_RESET;
    maxt_shadow = tstu_pkg::MAXT_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Find an angle near pi/2 whose cosine sums to exactly zero.
    zero_cos_arg = 32'sh0192_1FB5;
    zc_found = 1'b0;
    for (int d = -4096; d <= 4096; d++) begin
      probe = trig_value(tstu_pkg::OP_TAN, 32'sh0192_1FB5 + d);
      if (probe.st == tstu_pkg::ST_TANZERO) begin
        zero_cos_arg = 32'sh0192_1FB5 + d;
        zc_found = 1'b1;
        break;
      end
    end

    // Directed rows under the reset settings.
    rows = '{
      '{OP_SPARE6,          32'sh7FFF_FFFF,   1, 32'h0, tstu_pkg::ST_OK},
      '{OP_SPARE7,          32'sh8000_0000,   1, 32'h0, tstu_pkg::ST_OK},
      '{tstu_pkg::OP_SIN,   32'sh0,           1, 32'h0, tstu_pkg::ST_OK},
      '{tstu_pkg::OP_COS,   32'sh0,           1, ONE_Q, tstu_pkg::ST_OK},
      '{tstu_pkg::OP_TAN,   32'sh0,           1, 32'h0, tstu_pkg::ST_OK},
      '{tstu_pkg::OP_ASIN,  32'sh0,           1, 32'h0, tstu_pkg::ST_OK},
      '{tstu_pkg::OP_ATAN,  32'sh0,           1, 32'h0, tstu_pkg::ST_OK},
      '{tstu_pkg::OP_ACOS,  32'sh0,           0, 32'h0, tstu_pkg::ST_OK},
      '{tstu_pkg::OP_SIN,   32'sh7FFF_FFFF,   0, 32'h0, tstu_pkg::ST_OK},
      '{tstu_pkg::OP_COS,   32'sh8000_0000,   0, 32'h0, tstu_pkg::ST_OK},
      '{tstu_pkg::OP_TAN,   32'sh8000_0000,   0, 32'h0, tstu_pkg::ST_OK},
      '{tstu_pkg::OP_ASIN,  32'sh7FFF_FFFF,   0, 32'h0, tstu_pkg::ST_OK},
      '{tstu_pkg::OP_ACOS,  32'sh8000_0000,   0, 32'h0, tstu_pkg::ST_OK},
      '{tstu_pkg::OP_ATAN,  32'sh7FFF_FFFF,   0, 32'h0, tstu_pkg::ST_OK},
      '{tstu_pkg::OP_SIN,   32'sh0100_0000,   0, 32'h0, tstu_pkg::ST_OK},
      '{tstu_pkg::OP_COS,   -32'sh0100_0000,  0, 32'h0, tstu_pkg::ST_OK},
      '{tstu_pkg::OP_ASIN,  32'sh0100_0000,   0, 32'h0, tstu_pkg::ST_OK},
      '{tstu_pkg::OP_ACOS,  -32'sh0100_0000,  0, 32'h0, tstu_pkg::ST_OK},
      '{tstu_pkg::OP_ATAN,  32'sh0080_0000,   0, 32'h0, tstu_pkg::ST_OK},
      '{tstu_pkg::OP_ATAN,  -32'sh0200_0000,  0, 32'h0, tstu_pkg::ST_OK},
      '{tstu_pkg::OP_TAN,   32'sh0080_0000,   0, 32'h0, tstu_pkg::ST_OK},
      '{tstu_pkg::OP_TAN,   zero_cos_arg,     zc_found, 32'h0, tstu_pkg::ST_TANZERO},
      '{tstu_pkg::OP_TAN,   zero_cos_arg - 1, 0, 32'h0, tstu_pkg::ST_OK},
      '{tstu_pkg::OP_TAN,   zero_cos_arg + 1, 0, 32'h0, tstu_pkg::ST_OK}
    };
    foreach (rows[i])
      send_beat(rows[i].op, rows[i].arg, rows[i].typed, '{res: rows[i].res, st: rows[i].st});

    // Random phases: each with its own settings and idling pattern.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin set_config(16'd168, 7'd32); send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin set_config(16'd0, 7'd64);   send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin set_config(16'hFFFF, 7'd1); send_idle_pct = 0;  recv_stall_pct = 79; end
        3: begin set_config(16'd1000, 7'd8); send_idle_pct = 37; recv_stall_pct = 37; end
        default: begin
          set_config(16'd168, 7'd16);
          send_idle_pct = 0;
          recv_stall_pct = 0;
          // Hold the result side off long enough for the unit to back up.
          fork
            begin
              hold_on <= 1'b1;
              repeat (6000) @(posedge clk);
              hold_on <= 1'b0;
            end
          join_none
        end
      endcase
      n_items = 0;
      while (n_items < 185) begin
        send_beat(pick_op(), pick_arg(ph == 1 ? 3 : 8), 0, none);
        n_items++;
      end
    end
    in_valid <= 1'b0;

    // Drain, then allow the unit to settle.
    while (pending_vals.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (err_count == 0 && pending_vals.size() == 0) begin
      $display("** taylor_series_trig_unit_top: PASSED **");
    end else begin
      $display("** taylor_series_trig_unit_top: FAILED **");
    end
    $finish;
  end

endmodule
